[rtl/sadeq_pkg.sv]
// shared constants, command and status codes and cell control type for the sorted area queue
`default_nettype none

package sadeq_pkg;

  localparam int AREA_SIZE    = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int KEY_BITS     = 32;
  localparam int CNT_W        = $clog2(AREA_SIZE + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_RM_MIN = 2'd1,
    CMD_RM_MAX = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic                           do_insert;
    logic                           do_rm_min;
    logic signed [KEY_BITS-1:0]     new_key;
    logic        [PAYLOAD_BITS-1:0] new_payload;
  } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/sorted_area_double_ended_queue.sv]
// top level of the sorted area double-ended priority queue
// usage:
//   input channel carries one command per transaction: cmd, key, payload.
//   insert puts the record at its sorted place; remove smallest / largest
//   pops from either end. every command gives exactly one result
//   transaction: out_key, out_payload, status and occupancy.
//   the records sit in a row of 16 cells; on insert every cell compares its
//   key with the new key and either keeps, takes the new record or takes its
//   left neighbor's; on remove smallest every cell takes its right neighbor's.
//   result: registered, and shown in the cycle after the command is taken.
//   throughput: one command per cycle while not stalled, set by the single
//   compare-and-shift step of the cell row; the result register is the only buffer.
//   stall: while a result waits with stall high, in stall is raised and no
//   new command is taken; a result taken in the same cycle frees the slot.
//   reset (rst, synchronous): count and result valid clear, store is empty.
//   an insert into a full store or a removal from an empty one reports
//   status full / empty with zero key and payload and changes nothing.
`default_nettype none

module sorted_area_double_ended_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [1:0]  cmd,
  input  wire logic signed [31:0] key,
  input  wire logic        [31:0] payload,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed      [31:0] out_key,
  output logic             [31:0] out_payload,
  output logic             [1:0]  status,
  output logic             [4:0]  occupancy
);

  localparam int N  = sadeq_pkg::AREA_SIZE;
  localparam int KW = sadeq_pkg::KEY_BITS;
  localparam int PW = sadeq_pkg::PAYLOAD_BITS;
  localparam int CW = sadeq_pkg::CNT_W;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic signed [KW-1:0] cell_key     [N];
  logic        [PW-1:0] cell_payload [N];
  logic                 cell_stop    [N];

  sadeq_pkg::cell_ctl_t ctl;
  sadeq_pkg::cmd_t      cmd_code;

  logic accept;
  logic full;
  logic empty;

  // result of the command being taken
  logic signed [KW-1:0] res_key;
  logic        [PW-1:0] res_payload;
  logic        [1:0]    res_status;
  logic signed [KW-1:0] last_key;
  logic        [PW-1:0] last_payload;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign cmd_code = sadeq_pkg::cmd_t'(cmd);
  assign full     = count == CW'(N);
  assign empty    = count == '0;

  assign ctl.do_insert   = accept && (cmd_code == sadeq_pkg::CMD_INSERT) && !full;
  assign ctl.do_rm_min   = accept && (cmd_code == sadeq_pkg::CMD_RM_MIN) && !empty;
  assign ctl.new_key     = key;
  assign ctl.new_payload = payload[PW-1:0];

  // the cell row, neighbors wired left and right
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [KW-1:0] lk;
    logic        [PW-1:0] lp;
    logic signed [KW-1:0] rk;
    logic        [PW-1:0] rp;
    logic                 sp;
    logic                 sh;

    // the head cell never looks at its own stop
    if (i == 0) begin : g_head
      assign lk = '0;
      assign lp = '0;
      assign sp = 1'b0;
      assign sh = 1'b0;
    end else begin : g_body
      assign lk = cell_key[i-1];
      assign lp = cell_payload[i-1];
      assign sp = cell_stop[i-1];
      assign sh = cell_stop[0];
    end

    if (i == N - 1) begin : g_tail
      assign rk = '0;
      assign rp = '0;
    end else begin : g_inner
      assign rk = cell_key[i+1];
      assign rp = cell_payload[i+1];
    end

    sadeq_cell u_cell (
      .clk           (clk),
      .ctl           (ctl),
      .is_head       (i == 0),
      .occupied      (count > CW'(i)),
      .stop_prev     (sp),
      .stop_head     (sh),
      .left_key      (lk),
      .left_payload  (lp),
      .right_key     (rk),
      .right_payload (rp),
      .key           (cell_key[i]),
      .payload       (cell_payload[i]),
      .stop          (cell_stop[i])
    );
  end

  // pick the tail record: at most one cell matches count - 1, none when the store is empty
  always_comb begin
    last_key     = '0;
    last_payload = '0;
    for (int i = 0; i < N; i++) begin
      if (count == CW'(i + 1)) begin
        last_key     = last_key | cell_key[i];
        last_payload = last_payload | cell_payload[i];
      end
    end
  end

  always_comb begin
    res_key     = '0;
    res_payload = '0;
    res_status  = sadeq_pkg::ST_DONE;
    count_next  = count;
    case (cmd_code)
      sadeq_pkg::CMD_INSERT: begin
        if (full) begin
          res_status = sadeq_pkg::ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      sadeq_pkg::CMD_RM_MIN: begin
        if (empty) begin
          res_status = sadeq_pkg::ST_EMPTY;
        end else begin
          res_key     = cell_key[0];
          res_payload = cell_payload[0];
          count_next  = count - CW'(1);
        end
      end
      sadeq_pkg::CMD_RM_MAX: begin
        if (empty) begin
          res_status = sadeq_pkg::ST_EMPTY;
        end else begin
          res_key     = last_key;
          res_payload = last_payload;
          count_next  = count - CW'(1);
        end
      end
      default: begin
        res_status = sadeq_pkg::ST_DONE;
      end
    endcase
  end

  // occupancy and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register, held while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      out_key     <= res_key;
      out_payload <= 32'(res_payload);
      status      <= res_status;
      occupancy   <= 5'(count_next);
    end
  end

endmodule

`default_nettype wire

[rtl/sadeq_cell.sv]
// one slot of the sorted chain: holds a record and shifts with its neighbors
`default_nettype none

module sadeq_cell (
  input  wire logic                                     clk,
  input  wire sadeq_pkg::cell_ctl_t                     ctl,
  input  wire logic                                     is_head,
  input  wire logic                                     occupied,
  input  wire logic                                     stop_prev,
  input  wire logic                                     stop_head,
  input  wire logic signed [sadeq_pkg::KEY_BITS-1:0]     left_key,
  input  wire logic        [sadeq_pkg::PAYLOAD_BITS-1:0] left_payload,
  input  wire logic signed [sadeq_pkg::KEY_BITS-1:0]     right_key,
  input  wire logic        [sadeq_pkg::PAYLOAD_BITS-1:0] right_payload,
  output logic signed      [sadeq_pkg::KEY_BITS-1:0]     key,
  output logic             [sadeq_pkg::PAYLOAD_BITS-1:0] payload,
  output logic                                          stop
);

  logic take_left;

  // stop: the new record lands here or in front of this slot
  always_comb begin
    if (!occupied) begin
      stop = 1'b1;
    end else if (is_head) begin
      stop = ctl.new_key < key;
    end else begin
      stop = !(key < ctl.new_key);
    end
    take_left = is_head ? 1'b0 : (stop_head || stop_prev);
  end

  always_ff @(posedge clk) begin
    if (ctl.do_insert) begin
      if (take_left) begin
        key     <= left_key;
        payload <= left_payload;
      end else if (stop) begin
        key     <= ctl.new_key;
        payload <= ctl.new_payload;
      end
    end else if (ctl.do_rm_min) begin
      key     <= right_key;
      payload <= right_payload;
    end
  end

endmodule

`default_nettype wire

[tb/testbench.sv]
// self-checking testbench for the sorted area double-ended priority queue
`timescale 1ns / 1ps

module testbench;
  import sadeq_pkg::*;

  localparam logic [31:0] PAYLOAD_KEEP =
    (PAYLOAD_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << PAYLOAD_BITS) - 32'd1);
  localparam int N_RANDOM = 800;

  // one expected result transaction
  typedef struct {
    logic signed [31:0] rec_key;
    logic        [31:0] rec_payload;
    status_t            st;
    logic        [4:0]  occ;
  } area_result_t;

  // tracks the sorted store, queues the outcome of every accepted command
  // and compares each result transaction against the oldest one due
  class area_tracker;
    logic signed [31:0] area_key     [AREA_SIZE];
    logic        [31:0] area_payload [AREA_SIZE];
    int                 held;
    area_result_t       outcomes_due [$];
    int                 n_checked;
    int                 n_errors;
    int                 n_full;
    int                 n_empty;
    int                 n_sent;

    function new();
      held      = 0;
      n_checked = 0;
      n_errors  = 0;
      n_full    = 0;
      n_empty   = 0;
      n_sent    = 0;
    endfunction

    function void note_command(cmd_t c, logic signed [31:0] k, logic [31:0] p);
      area_result_t r;
      int           pos;
      r.rec_key     = '0;
      r.rec_payload = '0;
      r.st          = ST_DONE;
      n_sent++;
      case (c)
        CMD_INSERT: begin
          if (held >= AREA_SIZE) begin
            r.st = ST_FULL;
            n_full++;
          end else begin
            // a key below the head becomes the head; otherwise it goes
            // after the head, ahead of the first later key not below it
            if (held == 0 || k < area_key[0]) begin
              pos = 0;
            end else begin
              pos = 1;
              while (pos < held && area_key[pos] < k) pos++;
            end
            for (int i = held; i > pos; i--) begin
              area_key[i]     = area_key[i-1];
              area_payload[i] = area_payload[i-1];
            end
            area_key[pos]     = k;
            area_payload[pos] = p & PAYLOAD_KEEP;
            held++;
          end
        end
        CMD_RM_MIN, CMD_RM_MAX: begin
          if (held == 0) begin
            r.st = ST_EMPTY;
            n_empty++;
          end else if (c == CMD_RM_MIN) begin
            r.rec_key     = area_key[0];
            r.rec_payload = area_payload[0];
            for (int i = 1; i < held; i++) begin
              area_key[i-1]     = area_key[i];
              area_payload[i-1] = area_payload[i];
            end
            held--;
          end else begin
            r.rec_key     = area_key[held-1];
            r.rec_payload = area_payload[held-1];
            held--;
          end
        end
        default: ;
      endcase
      r.occ = held[4:0];
      outcomes_due.push_back(r);
    endfunction

    function void check_result(logic signed [31:0] k, logic [31:0] p,
                               logic [1:0] st, logic [4:0] occ);
      area_result_t r;
      if (outcomes_due.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("error: result with nothing outstanding: key %0d payload %h",
                   k, p);
        return;
      end
      r = outcomes_due.pop_front();
      n_checked++;
      if (r.rec_key !== k || r.rec_payload !== p || r.st !== st || r.occ !== occ) begin
        n_errors++;
        if (n_errors <= 10)
          $display("mismatch %0d: exp key %0d pay %h st %0d occ %0d, got key %0d pay %h st %0d occ %0d",
                   n_checked, r.rec_key, r.rec_payload, r.st, r.occ, k, p, st, occ);
      end
    endfunction

    function int outstanding();
      return outcomes_due.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic        [1:0]  cmd;
  logic signed [31:0] key;
  logic        [31:0] payload;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_key;
  logic        [31:0] out_payload;
  logic        [1:0]  status;
  logic        [4:0]  occupancy;

  area_tracker tracker = new();
  bit          quiet   = 0;   // no sender gaps during this phase

  sorted_area_double_ended_queue u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .key         (key),
    .payload     (payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_key     (out_key),
    .out_payload (out_payload),
    .status      (status),
    .occupancy   (occupancy)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // keys: a narrow band for duplicates, the extremes, or anything
  function automatic logic signed [31:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $signed($urandom_range(0, 8)) - 4;
    if (r == 4) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // present one command transaction and hold it until it is taken;
  // called at a rising edge, returns at the edge of acceptance
  task automatic send_command(cmd_t c, logic signed [31:0] k, logic [31:0] p);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    key      <= k;
    payload  <= p;
    do @(posedge clk); while (in_stall);
    tracker.note_command(c, k, p);
  endtask

  // result side: check taken results, stall in random bursts
  initial begin
    int run_left;
    int stall_left;
    run_left   = 0;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && !out_stall)
        tracker.check_result(out_key, out_payload, status, occupancy);
      if (run_left > 0) begin
        run_left--;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        // sometimes a long stretch without any stall
        run_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 120)
                                                 : $urandom_range(0, 4);
        stall_left = pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  // stimulus: directed opening, then phased random traffic
  initial begin
    logic signed [31:0] fill_keys [16];
    int   phase_left;
    int   phase_kind;
    int   r;
    cmd_t c;

    fill_keys = '{32'sd100, 32'sd100, 32'sd50, 32'sd100, 32'sh7FFF_FFFF,
                  32'sh8000_0000, -32'sd1, 32'sd0, 32'sd75, 32'sd75,
                  32'sd100, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd50,
                  -32'sd7, 32'sd75};

    rst       = 1'b1;
    in_valid  = 1'b0;
    cmd       = CMD_NOP;
    key       = '0;
    payload   = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // removals from the empty store, the unused code, a lone entry leaving
    send_command(CMD_RM_MIN, $urandom, $urandom);
    send_command(CMD_RM_MAX, $urandom, $urandom);
    send_command(CMD_NOP, $urandom, $urandom);
    send_command(CMD_INSERT, 32'sd5, 32'hFFFF_FFFF);
    send_command(CMD_RM_MAX, $urandom, $urandom);

    // fill to capacity with duplicates of the head and of later keys;
    // the payload tells equal keys apart
    for (int i = 0; i < 16; i++)
      send_command(CMD_INSERT, fill_keys[i],
                   (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : 32'h1000 + i);
    send_command(CMD_INSERT, 32'sd1, 32'hDEAD_BEEF);   // store full
    send_command(CMD_RM_MAX, $urandom, $urandom);
    send_command(CMD_RM_MIN, $urandom, $urandom);
    send_command(CMD_NOP, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);

    // random part: phases that push toward full, toward empty or hover
    phase_left = 0;
    phase_kind = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 60);
        phase_kind = $urandom_range(0, 2);
        quiet      = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      r = $urandom_range(0, 99);
      case (phase_kind)
        0:       c = (r < 75) ? CMD_INSERT : (r < 87) ? CMD_RM_MIN
                   : (r < 97) ? CMD_RM_MAX : CMD_NOP;
        1:       c = (r < 25) ? CMD_INSERT : (r < 60) ? CMD_RM_MIN
                   : (r < 97) ? CMD_RM_MAX : CMD_NOP;
        default: c = (r < 48) ? CMD_INSERT : (r < 72) ? CMD_RM_MIN
                   : (r < 96) ? CMD_RM_MAX : CMD_NOP;
      endcase
      send_command(c, pick_key(), $urandom);
    end
    in_valid <= 1'b0;

    // drain, then keep waiting for any stray result transaction
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d commands, %0d results checked, %0d errors", tracker.n_sent,
             tracker.n_checked, tracker.n_errors);
    $display("inserts refused on a full store: %0d, removals from an empty store: %0d",
             tracker.n_full, tracker.n_empty);
    if (tracker.n_errors == 0 && tracker.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
